// ===== rtl/ljdp_pkg.sv =====
`default_nettype none
package ljdp_pkg;

  localparam int NUM_BINS_DEF      = 50;
  localparam int COUNT_BITS_DEF    = 32;
  localparam int PHI_FRAC_BITS_DEF = 13;

  localparam int ANG_FRAC     = 30;
  localparam int CORDIC_STEPS = 30;
  localparam int PRE_SHIFT    = 24;
  localparam int CXY_W        = 60;
  localparam int Z_W          = 34;

  localparam logic [Z_W-1:0] PI_Q30      = 34'd3373259426;
  localparam logic [Z_W-1:0] HALF_PI_Q30 = 34'd1686629713;

  localparam logic CMD_JET  = 1'b0;
  localparam logic CMD_READ = 1'b1;
  localparam logic KIND_EVENT = 1'b0;
  localparam logic KIND_BIN   = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD_WAIT, S_RD_OUT, S_CL_START, S_CL_WAIT, S_CS_START, S_CS_WAIT,
    S_DELTA, S_BIN_START, S_BIN_RUN, S_HRD, S_HWR, S_OUT_EV
  } state_t;

  // Pi rounded to frac fraction bits, the same way the angles are rounded.
  function automatic longint pi_q(input int frac);
    longint s;
    s = ANG_FRAC - frac;
    return (longint'(PI_Q30) + (longint'(1) << (s - 1))) >>> s;
  endfunction

  // atan(2^-i) in Q2.30.
  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0: r = 32'd843314857;
      5'd1: r = 32'd497837829;
      5'd2: r = 32'd263043837;
      5'd3: r = 32'd133525159;
      5'd4: r = 32'd67021687;
      5'd5: r = 32'd33543516;
      5'd6: r = 32'd16775851;
      5'd7: r = 32'd8388437;
      5'd8: r = 32'd4194283;
      5'd9: r = 32'd2097149;
      default: r = 32'd1 << (5'd30 - i);
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/ljdp_cordic.sv =====
`default_nettype none
module ljdp_cordic #(
  parameter int PHI_FRAC_BITS = ljdp_pkg::PHI_FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic signed [31:0]            x_in,
  input  wire logic signed [31:0]            y_in,
  output logic                               done,
  output logic signed [PHI_FRAC_BITS+2:0]    phi
);
  localparam int PHI_W = PHI_FRAC_BITS + 3;
  localparam int SH    = ljdp_pkg::ANG_FRAC - PHI_FRAC_BITS;
  localparam int CW    = ljdp_pkg::CXY_W;
  localparam int ZW    = ljdp_pkg::Z_W;
  localparam logic signed [ZW-1:0] PI_Z = ZW'(ljdp_pkg::pi_q(PHI_FRAC_BITS));
  localparam logic signed [ZW-1:0] HALF = ZW'(1) <<< (SH - 1);
  localparam logic signed [ZW-1:0] HALF_PI_Z = ljdp_pkg::HALF_PI_Q30;

  logic signed [CW-1:0] x_r, y_r, xs, ys, x0, y0;
  logic signed [ZW-1:0] z_r, at, zr;
  logic [4:0] cnt_r;
  logic busy_r, fin_r, zero_r;

  assign x0 = {{(CW-32-ljdp_pkg::PRE_SHIFT){x_in[31]}}, x_in, {ljdp_pkg::PRE_SHIFT{1'b0}}};
  assign y0 = {{(CW-32-ljdp_pkg::PRE_SHIFT){y_in[31]}}, y_in, {ljdp_pkg::PRE_SHIFT{1'b0}}};
  assign xs = x_r >>> cnt_r;
  assign ys = y_r >>> cnt_r;
  assign at = ZW'(ljdp_pkg::atan_q30(cnt_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
    end else begin
      fin_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        zero_r <= (x_in == 0) && (y_in == 0);
        // Vectors in the left half plane are first turned by a quarter turn.
        if (x_in[31] && !y_in[31]) begin
          x_r <= y0; y_r <= -x0; z_r <= HALF_PI_Z;
        end else if (x_in[31]) begin
          x_r <= -y0; y_r <= x0; z_r <= -HALF_PI_Z;
        end else begin
          x_r <= x0; y_r <= y0; z_r <= '0;
        end
      end else if (busy_r) begin
        if (!y_r[CW-1]) begin
          x_r <= x_r + ys; y_r <= y_r - xs; z_r <= z_r + at;
        end else begin
          x_r <= x_r - ys; y_r <= y_r + xs; z_r <= z_r - at;
        end
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'(ljdp_pkg::CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    zr = (z_r + HALF) >>> SH;
    if (zr > PI_Z) zr = PI_Z;
    if (zr < -PI_Z) zr = -PI_Z;
    phi = zero_r ? '0 : zr[PHI_W-1:0];
  end

  assign done = fin_r;
endmodule
`default_nettype wire

// ===== rtl/leading_jet_pair_delta_phi.sv =====
`default_nettype none
// Tracks the two most energetic jets of each event (ties keep the earlier jet) and, at the
// last jet of an event with at least two jets, returns the azimuth of both and their
// wrapped difference while adding them to saturating phi and delta-phi histograms; a read
// command returns one bin. An event end runs the shared iterative CORDIC unit for the
// leading and then the subleading jet, then for each of the three histogram updates a bin
// computation for in-range values (a multiply by the bin count, a reciprocal multiply and
// a one-step correction) and a read-modify-write on the bin memory. A bin read passes
// through a wait state for the memory read. After reset the two bin memories are cleared,
// one entry a cycle, over all NUM_BINS+2 entries, during which no transaction is accepted.
module leading_jet_pair_delta_phi #(
  parameter int NUM_BINS      = ljdp_pkg::NUM_BINS_DEF,
  parameter int COUNT_BITS    = ljdp_pkg::COUNT_BITS_DEF,
  parameter int PHI_FRAC_BITS = ljdp_pkg::PHI_FRAC_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // jet_energy[31:0], mom_x[63:32], mom_y[95:64], bin_index[101:96], zero fill
  input  wire logic [103:0] in_tdata,
  // command[0], hist_select[1]
  input  wire logic [1:0]   in_tuser,
  input  wire logic         in_tlast,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // phi_lead, phi_sub, delta_phi (PHI_FRAC_BITS+3 bits each), bin_count (32), zero fill
  output logic [((3*(PHI_FRAC_BITS+3)+32+7)/8)*8-1:0] out_tdata,
  // kind
  output logic              out_tuser
);
  localparam int PHI_W = PHI_FRAC_BITS + 3;
  localparam int OUT_W = ((3*PHI_W+32+7)/8)*8;
  localparam int SLOTS = NUM_BINS + 2;
  localparam int AW    = $clog2(SLOTS);
  localparam int QW    = $clog2(NUM_BINS + 1);
  localparam int NW    = PHI_W + 1 + QW;
  localparam int PW    = NW + QW + 2;
  localparam logic signed [PHI_W-1:0] PI_S = PHI_W'(ljdp_pkg::pi_q(PHI_FRAC_BITS));
  localparam logic [NW-1:0] DIV = NW'(2 * ljdp_pkg::pi_q(PHI_FRAC_BITS));
  localparam logic [QW+1:0] RECIP =
    (QW+2)'((longint'(1) << NW) / (2 * ljdp_pkg::pi_q(PHI_FRAC_BITS)));
  localparam logic [COUNT_BITS-1:0] MAXC = '1;

  ljdp_pkg::state_t state_r, state_nxt;

  logic [31:0] e_in;
  logic [63:0] xy_in;
  logic [5:0]  idx_in;
  assign e_in   = in_tdata[31:0];
  assign xy_in  = in_tdata[95:32];
  assign idx_in = in_tdata[101:96];

  logic [31:0] lead_e_r, sub_e_r;
  logic [63:0] lead_xy_r, sub_xy_r;
  logic [1:0]  seen_r;
  logic [1:0]  seen_inc;
  assign seen_inc = (seen_r == 2'd2) ? 2'd2 : seen_r + 2'd1;

  logic acc, out_free, out_load;
  assign acc      = in_tvalid && in_tready;
  assign out_free = !out_tvalid || out_tready;
  assign out_load = out_free &&
                    (state_r == ljdp_pkg::S_RD_OUT || state_r == ljdp_pkg::S_OUT_EV);
  assign in_tready = (state_r == ljdp_pkg::S_IDLE);

  // CORDIC
  logic cor_start, cor_done, cor_sub;
  logic signed [PHI_W-1:0] cor_phi;
  logic [63:0] cor_xy;
  assign cor_sub   = (state_r == ljdp_pkg::S_CS_START);
  assign cor_start = (state_r == ljdp_pkg::S_CL_START) || cor_sub;
  assign cor_xy    = cor_sub ? sub_xy_r : lead_xy_r;

  ljdp_cordic #(.PHI_FRAC_BITS(PHI_FRAC_BITS)) u_cordic (
    .clk(clk), .rst_n(rst_n), .start(cor_start),
    .x_in(cor_xy[31:0]), .y_in(cor_xy[63:32]),
    .done(cor_done), .phi(cor_phi)
  );

  logic signed [PHI_W-1:0] p1_r, p2_r, d_r, v;
  logic signed [PHI_W:0]   diff, dwrap;
  logic [1:0] upd_r;
  logic [NW-1:0] rem_r, chk;
  logic [PW-1:0] prod;
  logic [QW-1:0] q_r;
  logic k_r;
  logic [AW-1:0] addr_r, clr_r;
  logic hsel_r, oob_r;

  assign diff = {p1_r[PHI_W-1], p1_r} - {p2_r[PHI_W-1], p2_r};
  always_comb begin
    dwrap = diff;
    if (diff > $signed({PI_S[PHI_W-1], PI_S}))
      dwrap = diff - $signed({PI_S, 1'b0});
    else if (diff < -$signed({PI_S[PHI_W-1], PI_S}))
      dwrap = diff + $signed({PI_S, 1'b0});
  end

  always_comb begin
    case (upd_r)
      2'd0:    v = p1_r;
      2'd1:    v = p2_r;
      default: v = d_r;
    endcase
  end

  logic [PHI_W:0] u;
  assign u     = $unsigned({v[PHI_W-1], v} + {PI_S[PHI_W-1], PI_S});
  // The reciprocal estimate is at most one below the true quotient; chk corrects it.
  assign prod  = PW'(rem_r) * PW'(RECIP);
  assign chk   = rem_r - NW'(q_r) * DIV;

  // Bin memories.
  logic [COUNT_BITS-1:0] phi_mem [SLOTS];
  logic [COUNT_BITS-1:0] dphi_mem [SLOTS];
  logic [COUNT_BITS-1:0] phi_rd_r, dphi_rd_r, cur, inc;
  logic clearing, we_phi, we_dphi;
  logic [AW-1:0] wa;
  logic [COUNT_BITS-1:0] wd;

  assign clearing = (state_r == ljdp_pkg::S_CLEAR);
  assign cur      = (upd_r == 2'd2) ? dphi_rd_r : phi_rd_r;
  assign inc      = (cur < MAXC) ? cur + 1'b1 : cur;
  assign we_phi   = clearing || (state_r == ljdp_pkg::S_HWR && upd_r != 2'd2);
  assign we_dphi  = clearing || (state_r == ljdp_pkg::S_HWR && upd_r == 2'd2);
  assign wa       = clearing ? clr_r : addr_r;
  assign wd       = clearing ? '0 : inc;

  always_ff @(posedge clk) begin
    if (we_phi) phi_mem[wa] <= wd;
    if (we_dphi) dphi_mem[wa] <= wd;
    phi_rd_r  <= phi_mem[addr_r];
    dphi_rd_r <= dphi_mem[addr_r];
  end

  logic [COUNT_BITS+31:0] rd_ext;
  assign rd_ext = {32'd0, (hsel_r ? dphi_rd_r : phi_rd_r)};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ljdp_pkg::S_CLEAR:    if (clr_r == AW'(SLOTS - 1)) state_nxt = ljdp_pkg::S_IDLE;
      ljdp_pkg::S_IDLE: begin
        if (acc) begin
          if (in_tuser[0] == ljdp_pkg::CMD_READ) state_nxt = ljdp_pkg::S_RD_WAIT;
          else if (in_tlast && seen_inc == 2'd2) state_nxt = ljdp_pkg::S_CL_START;
        end
      end
      ljdp_pkg::S_RD_WAIT:  state_nxt = ljdp_pkg::S_RD_OUT;
      ljdp_pkg::S_RD_OUT:   if (out_free) state_nxt = ljdp_pkg::S_IDLE;
      ljdp_pkg::S_CL_START: state_nxt = ljdp_pkg::S_CL_WAIT;
      ljdp_pkg::S_CL_WAIT:  if (cor_done) state_nxt = ljdp_pkg::S_CS_START;
      ljdp_pkg::S_CS_START: state_nxt = ljdp_pkg::S_CS_WAIT;
      ljdp_pkg::S_CS_WAIT:  if (cor_done) state_nxt = ljdp_pkg::S_DELTA;
      ljdp_pkg::S_DELTA:    state_nxt = ljdp_pkg::S_BIN_START;
      ljdp_pkg::S_BIN_START: begin
        if (v < -PI_S || v >= PI_S) state_nxt = ljdp_pkg::S_HRD;
        else state_nxt = ljdp_pkg::S_BIN_RUN;
      end
      ljdp_pkg::S_BIN_RUN:  if (!k_r) state_nxt = ljdp_pkg::S_HRD;
      ljdp_pkg::S_HRD:      state_nxt = ljdp_pkg::S_HWR;
      ljdp_pkg::S_HWR: begin
        if (upd_r == 2'd2) state_nxt = ljdp_pkg::S_OUT_EV;
        else state_nxt = ljdp_pkg::S_BIN_START;
      end
      ljdp_pkg::S_OUT_EV:   if (out_free) state_nxt = ljdp_pkg::S_IDLE;
      default:              state_nxt = ljdp_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ljdp_pkg::S_CLEAR;
      clr_r      <= '0;
      seen_r     <= 2'd0;
      lead_e_r   <= '0; lead_xy_r <= '0;
      sub_e_r    <= '0; sub_xy_r  <= '0;
      out_tvalid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) out_tvalid <= 1'b1;
      else if (out_tready) out_tvalid <= 1'b0;
      case (state_r)
        ljdp_pkg::S_CLEAR: clr_r <= clr_r + 1'b1;
        ljdp_pkg::S_IDLE: begin
          if (acc && in_tuser[0] == ljdp_pkg::CMD_READ) begin
            hsel_r <= in_tuser[1];
            oob_r  <= idx_in >= 6'(SLOTS > 63 ? 63 : SLOTS) && SLOTS <= 63;
            addr_r <= AW'(idx_in);
          end else if (acc) begin
            if (seen_r == 2'd0) begin
              lead_e_r <= e_in; lead_xy_r <= xy_in;
            end else if (e_in > lead_e_r) begin
              sub_e_r <= lead_e_r; sub_xy_r <= lead_xy_r;
              lead_e_r <= e_in; lead_xy_r <= xy_in;
            end else if (seen_r == 2'd1 || e_in > sub_e_r) begin
              sub_e_r <= e_in; sub_xy_r <= xy_in;
            end
            seen_r <= in_tlast ? 2'd0 : seen_inc;
          end
        end
        ljdp_pkg::S_RD_OUT: begin
          if (out_free) begin
            out_tuser  <= ljdp_pkg::KIND_BIN;
            out_tdata  <= {(OUT_W-3*PHI_W)'(oob_r ? 32'd0 : rd_ext[31:0]), {(3*PHI_W){1'b0}}};
          end
        end
        ljdp_pkg::S_CL_WAIT: if (cor_done) p1_r <= cor_phi;
        ljdp_pkg::S_CS_WAIT: if (cor_done) p2_r <= cor_phi;
        ljdp_pkg::S_DELTA: begin
          d_r   <= dwrap[PHI_W-1:0];
          upd_r <= 2'd0;
        end
        ljdp_pkg::S_BIN_START: begin
          if (v < -PI_S) addr_r <= '0;
          else if (v >= PI_S) addr_r <= AW'(NUM_BINS + 1);
          rem_r <= NW'(u) * NW'(NUM_BINS);
          k_r   <= 1'b1;
        end
        ljdp_pkg::S_BIN_RUN: begin
          k_r <= 1'b0;
          if (k_r) q_r <= prod[NW+QW-1:NW];
          else if (chk >= DIV) addr_r <= AW'(q_r) + AW'(2);
          else addr_r <= AW'(q_r) + AW'(1);
        end
        ljdp_pkg::S_HWR: upd_r <= upd_r + 2'd1;
        ljdp_pkg::S_OUT_EV: begin
          if (out_free) begin
            out_tuser  <= ljdp_pkg::KIND_EVENT;
            out_tdata  <= OUT_W'({d_r, p2_r, p1_r});
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
module testbench;

  localparam int NB = 50;
  localparam int SLOTS = NB + 2;
  localparam int FRACB = 13;
  localparam longint PIQ = 25736;
  localparam int WATCHDOG = 20000;

  typedef struct packed {
    logic        cmd;
    logic [31:0] energy;
    logic [31:0] mx;
    logic [31:0] my;
    logic        last;
    logic        sel;
    logic [5:0]  idx;
  } jet_item_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] phi_lead;
    logic [15:0] phi_sub;
    logic [15:0] dphi;
    logic [31:0] count;
  } event_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [103:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [79:0] out_tdata;
  logic out_tuser;

  leading_jet_pair_delta_phi u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always #1 clk = ~clk;

  jet_item_t pending_jets[$];
  event_result_t expected_results[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_for_drain = 1'b0;
  bit stim_done = 1'b0;
  int quiet_cycles = 0;

  // Shadow of the block's tracking state and histograms.
  logic [31:0] lead_e, sub_e;
  logic [31:0] lead_x, lead_y, sub_x, sub_y;
  int jets_seen = 0;
  longint unsigned phi_counts[SLOTS];
  longint unsigned dphi_counts[SLOTS];

  function automatic longint cordic_phi(logic [31:0] xi, logic [31:0] yi);
    longint x, y, z, xs, ys, r;
    longint atab[30] = '{843314857, 497837829, 263043837, 133525159, 67021687,
      33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
      131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64,
      32, 16, 8, 4, 2};
    x = longint'($signed(xi));
    y = longint'($signed(yi));
    z = 0;
    if (x == 0 && y == 0) return 0;
    x = x * (64'sd1 << 24);
    y = y * (64'sd1 << 24);
    if (x < 0) begin
      if (y >= 0) begin
        xs = x; x = y; y = -xs; z = 1686629713;
      end else begin
        xs = x; x = -y; y = xs; z = -1686629713;
      end
    end
    for (int i = 0; i < 30; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + atab[i];
      end else begin
        x = x - ys; y = y + xs; z = z - atab[i];
      end
    end
    r = (z + (64'sd1 << (30 - FRACB - 1))) >>> (30 - FRACB);
    if (r > PIQ) r = PIQ;
    if (r < -PIQ) r = -PIQ;
    return r;
  endfunction

  function automatic int bin_of(longint v);
    if (v < -PIQ) return 0;
    if (v >= PIQ) return NB + 1;
    return 1 + int'(((v + PIQ) * NB) / (2 * PIQ));
  endfunction

  task automatic predict_item(input jet_item_t it);
    event_result_t r;
    longint p1, p2, d;
    int b;
    r = '0;
    if (it.cmd == ljdp_pkg::CMD_READ) begin
      r.kind = ljdp_pkg::KIND_BIN;
      if (it.idx < SLOTS)
        r.count = it.sel ? dphi_counts[it.idx][31:0] : phi_counts[it.idx][31:0];
      expected_results.push_back(r);
      return;
    end
    if (jets_seen == 0) begin
      lead_e = it.energy; lead_x = it.mx; lead_y = it.my;
    end else if (it.energy > lead_e) begin
      sub_e = lead_e; sub_x = lead_x; sub_y = lead_y;
      lead_e = it.energy; lead_x = it.mx; lead_y = it.my;
    end else if (jets_seen == 1 || it.energy > sub_e) begin
      sub_e = it.energy; sub_x = it.mx; sub_y = it.my;
    end
    if (jets_seen < 2) jets_seen++;
    if (!it.last) return;
    if (jets_seen < 2) begin
      jets_seen = 0;
      return;
    end
    jets_seen = 0;
    p1 = cordic_phi(lead_x, lead_y);
    p2 = cordic_phi(sub_x, sub_y);
    d = p1 - p2;
    if (d > PIQ) d -= 2 * PIQ;
    else if (d < -PIQ) d += 2 * PIQ;
    b = bin_of(p1); if (phi_counts[b] < 64'hFFFF_FFFF) phi_counts[b]++;
    b = bin_of(p2); if (phi_counts[b] < 64'hFFFF_FFFF) phi_counts[b]++;
    b = bin_of(d); if (dphi_counts[b] < 64'hFFFF_FFFF) dphi_counts[b]++;
    r.kind = ljdp_pkg::KIND_EVENT;
    r.phi_lead = p1[15:0];
    r.phi_sub = p2[15:0];
    r.dphi = d[15:0];
    expected_results.push_back(r);
  endtask

  // Driver: the head of the queue is presented until it is taken.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_item(pending_jets.pop_front());
      end
      if ((!in_tvalid || in_tready) ) begin
        if (pending_jets.size() > ((in_tvalid && in_tready) ? 0 : 0) &&
            !(hold_for_drain && expected_results.size() != 0) &&
            $urandom_range(99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata <= {2'b00, pending_jets[0].idx, pending_jets[0].my,
                       pending_jets[0].mx, pending_jets[0].energy};
          in_tuser <= {pending_jets[0].sel, pending_jets[0].cmd};
          in_tlast <= pending_jets[0].last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor.
  always @(posedge clk) begin
    event_result_t got, exp_r;
    if (rst_n) begin
      if ((out_tvalid && out_tready) || (in_tvalid && in_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (out_tvalid && out_tready) begin
        got.kind = out_tuser;
        got.phi_lead = out_tdata[15:0];
        got.phi_sub = out_tdata[31:16];
        got.dphi = out_tdata[47:32];
        got.count = out_tdata[79:48];
        if (expected_results.size() == 0) begin
          $error("unexpected result kind=%0d", got.kind);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (got.kind != exp_r.kind) begin
            $error("kind: expected %0d, got %0d", exp_r.kind, got.kind); errors++;
          end
          if (got.phi_lead != exp_r.phi_lead) begin
            $error("phi_lead: expected %0d, got %0d", $signed(exp_r.phi_lead),
                   $signed(got.phi_lead)); errors++;
          end
          if (got.phi_sub != exp_r.phi_sub) begin
            $error("phi_sub: expected %0d, got %0d", $signed(exp_r.phi_sub),
                   $signed(got.phi_sub)); errors++;
          end
          if (got.dphi != exp_r.dphi) begin
            $error("delta_phi: expected %0d, got %0d", $signed(exp_r.dphi),
                   $signed(got.dphi)); errors++;
          end
          if (got.count != exp_r.count) begin
            $error("bin_count: expected %0d, got %0d", exp_r.count, got.count); errors++;
          end
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic logic [31:0] rand_mom();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'd0;
      3: return $urandom_range(200) - 100;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_jet(input logic [31:0] e, input logic [31:0] x, input logic [31:0] y,
                         input logic last);
    jet_item_t it;
    it = '0;
    it.cmd = ljdp_pkg::CMD_JET; it.energy = e; it.mx = x; it.my = y; it.last = last;
    it.sel = $urandom; it.idx = $urandom;
    pending_jets.push_back(it);
  endtask

  task automatic add_read(input logic sel, input logic [5:0] idx);
    jet_item_t it;
    it = '0;
    it.cmd = ljdp_pkg::CMD_READ; it.sel = sel; it.idx = idx;
    it.energy = $urandom; it.mx = $urandom; it.my = $urandom; it.last = $urandom;
    pending_jets.push_back(it);
  endtask

  task automatic add_random_event();
    int n;
    logic [31:0] e;
    n = $urandom_range(4, 1);
    for (int j = 0; j < n; j++) begin
      e = ($urandom_range(3) == 0) ? $urandom_range(3) : $urandom;
      if ($urandom_range(9) == 0) e = 32'hFFFF_FFFF;
      add_jet(e, rand_mom(), rand_mom(), j == n - 1);
      if ($urandom_range(9) == 0) add_read($urandom, $urandom_range(63));
    end
  endtask

  task automatic wait_drained();
    while (pending_jets.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    jets_seen = 0;
    for (int i = 0; i < SLOTS; i++) begin
      phi_counts[i] = 0; dphi_counts[i] = 0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: quadrant corners, axes, ties, lone jets, reads between jets.
    add_jet(32'd5, 32'd0, 32'd0, 1'b0);
    add_jet(32'd5, 32'h8000_0000, 32'd0, 1'b1);
    add_jet(32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
    add_read(1'b0, 6'd0);
    add_jet(32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    add_jet(32'd9, 32'd1, 32'd0, 1'b1);
    add_jet(32'd1, 32'hFFFF_FFFF, 32'd0, 1'b0);
    add_jet(32'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    add_jet(32'd3, 32'd0, 32'h7FFF_FFFF, 1'b1);
    add_jet(32'd7, 32'd0, 32'h8000_0000, 1'b0);
    add_jet(32'd7, 32'h8000_0000, 32'd1, 1'b0);
    add_jet(32'd7, 32'd3, 32'd3, 1'b1);
    add_read(1'b0, 6'd51);
    add_read(1'b1, 6'd51);
    add_read(1'b1, 6'd0);
    add_read(1'b0, 6'd63);
    add_read(1'b1, 6'd52);
    add_read(1'b0, 6'd26);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 64 : 24) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 64 : 24) : 0;
      while (pending_jets.size() < 290) add_random_event();
      if (ph == 2) begin
        while (pending_jets.size() != 0) @(posedge clk);
        hold_for_drain = 1'b1;
        add_random_event();
        add_random_event();
        while (pending_jets.size() != 0) @(posedge clk);
        hold_for_drain = 1'b0;
      end
      wait_drained();
    end
    for (int i = 0; i < SLOTS + 12; i++) add_read(i % 2, i[5:0]);
    for (int i = 0; i < SLOTS; i++) add_read(1'b1, i[5:0]);
    wait_drained();
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
